@@ sv/text_glyph_rasterizer_assert.svh @@
// Assertion macros for the glyph rasterizer checkers
`ifndef TEXT_GLYPH_RASTERIZER_ASSERT_SVH
`define TEXT_GLYPH_RASTERIZER_ASSERT_SVH

// clocked, disabled while reset is high
`define TGR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked, also checked during reset
`define TGR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/tgr_pkg.sv @@
// Shared types, constants and 5x8 glyph ROM contents for the glyph rasterizer
package tgr_pkg;

   localparam int DEF_SCREEN_WIDTH  = 240;
   localparam int DEF_SCREEN_HEIGHT = 135;

   localparam logic [7:0] FIRST_CODE   = 8'd32;
   localparam logic [7:0] LAST_CODE    = 8'd90;
   localparam logic [9:0] CELL_ADVANCE = 10'd6;
   localparam int         GLYPH_COLS   = 5;
   localparam int         GLYPH_ROWS   = 8;
   localparam int         GLYPH_COUNT  = 59;
   localparam int         ROM_DEPTH    = GLYPH_COUNT * GLYPH_COLS;
   localparam int         ROM_AW       = $clog2(ROM_DEPTH);

   typedef struct packed {
      logic [8:0]        x0;
      logic [7:0]        y0;
      logic [ROM_AW-1:0] rom_base;
      logic [15:0]       fg_color;
      logic [15:0]       back_color;
      logic [2:0]        last_col;
      logic [2:0]        last_row;
   } tgr_job_type;

   localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
      8'h00,8'h00,8'h00,8'h00,8'h00,  8'h00,8'h00,8'hFA,8'h00,8'h00,
      8'h00,8'hE0,8'h00,8'hE0,8'h00,  8'h28,8'hFE,8'h28,8'hFE,8'h28,
      8'h48,8'h54,8'hFE,8'h54,8'h24,  8'h46,8'h26,8'h10,8'hC8,8'hC4,
      8'h6C,8'h92,8'hAA,8'h44,8'h0A,  8'h00,8'hC0,8'hA0,8'h00,8'h00,
      8'h00,8'h82,8'h44,8'h38,8'h00,  8'h00,8'h38,8'h44,8'h82,8'h00,
      8'h28,8'h10,8'h7C,8'h10,8'h28,  8'h10,8'h10,8'h7C,8'h10,8'h10,
      8'h00,8'h00,8'h0C,8'h0A,8'h00,  8'h10,8'h10,8'h10,8'h10,8'h10,
      8'h00,8'h00,8'h06,8'h06,8'h00,  8'h04,8'h08,8'h10,8'h20,8'h40,
      8'h7C,8'h8A,8'h92,8'hA2,8'h7C,  8'h00,8'h42,8'hFE,8'h02,8'h00,
      8'h42,8'h86,8'h8A,8'h92,8'h62,  8'h84,8'h82,8'hA2,8'hD2,8'h8C,
      8'h18,8'h28,8'h48,8'hFE,8'h08,  8'hE4,8'hA2,8'hA2,8'hA2,8'h9C,
      8'h3C,8'h52,8'h92,8'h92,8'h0C,  8'h80,8'h8E,8'h90,8'hA0,8'hC0,
      8'h6C,8'h92,8'h92,8'h92,8'h6C,  8'h60,8'h92,8'h92,8'h94,8'h78,
      8'h00,8'h6C,8'h6C,8'h00,8'h00,  8'h00,8'h6A,8'h6C,8'h00,8'h00,
      8'h00,8'h82,8'h44,8'h28,8'h10,  8'h28,8'h28,8'h28,8'h28,8'h28,
      8'h10,8'h28,8'h44,8'h82,8'h00,  8'h60,8'h80,8'h8A,8'h90,8'h60,
      8'h4C,8'h92,8'h9E,8'h82,8'h7C,  8'h7E,8'h88,8'h88,8'h88,8'h7E,
      8'hFE,8'h92,8'h92,8'h92,8'h6C,  8'h44,8'h82,8'h82,8'h82,8'h7C,
      8'h38,8'h44,8'h82,8'h82,8'hFE,  8'h82,8'h92,8'h92,8'h92,8'hFE,
      8'h80,8'h90,8'h90,8'h90,8'hFE,  8'h5E,8'h92,8'h92,8'h82,8'h7C,
      8'hFE,8'h10,8'h10,8'h10,8'hFE,  8'h00,8'h82,8'hFE,8'h82,8'h00,
      8'h80,8'hFC,8'h82,8'h02,8'h04,  8'h82,8'h44,8'h28,8'h10,8'hFE,
      8'h02,8'h02,8'h02,8'h02,8'hFE,  8'hFE,8'h40,8'h30,8'h40,8'hFE,
      8'hFE,8'h08,8'h10,8'h20,8'hFE,  8'h7C,8'h82,8'h82,8'h82,8'h7C,
      8'h60,8'h90,8'h90,8'h90,8'hFE,  8'h7A,8'h84,8'h8A,8'h82,8'h7C,
      8'h62,8'h94,8'h98,8'h90,8'hFE,  8'h8C,8'h92,8'h92,8'h92,8'h62,
      8'h80,8'h80,8'hFE,8'h80,8'h80,  8'hFC,8'h02,8'h02,8'h02,8'hFC,
      8'hF8,8'h04,8'h02,8'h04,8'hF8,  8'hFC,8'h02,8'h1C,8'h02,8'hFC,
      8'hC6,8'h28,8'h10,8'h28,8'hC6,  8'hE0,8'h10,8'h0E,8'h10,8'hE0,
      8'h86,8'h8A,8'h92,8'hA2,8'hC2
   };

endpackage

@@ sv/tgr_front.sv @@
// Character intake: cursor tracking, clipping bounds and job setup
module tgr_front import tgr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  char_code,
   input  logic [8:0]  start_x,
   input  logic [7:0]  start_y,
   input  logic        new_string,
   input  logic [15:0] fg_color,
   input  logic [15:0] back_color,
   output logic        job_load,
   output tgr_job_type job
);

   localparam logic [9:0] WIDTH_L  = 10'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_L = 9'(SCREEN_HEIGHT);

   logic [9:0] cursor_x_ff, cursor_x_in;
   logic [7:0] cursor_row_ff, cursor_row_in;
   logic [9:0] place_x;
   logic [7:0] place_y;
   logic       draw;
   logic       rows_on;
   logic [9:0] rem_x;
   logic [8:0] rem_y;
   logic [5:0] glyph_idx;

   always_comb begin
      place_x = new_string ? {1'b0, start_x} : cursor_x_ff;
      place_y = new_string ? start_y : cursor_row_ff;
      draw    = place_x < WIDTH_L;
      rows_on = {1'b0, place_y} < HEIGHT_L;
      rem_x   = WIDTH_L - 10'd1 - place_x;
      rem_y   = HEIGHT_L - 9'd1 - {1'b0, place_y};

      if (char_code >= FIRST_CODE && char_code <= LAST_CODE) begin
         glyph_idx = 6'(char_code - FIRST_CODE);
      end else begin
         glyph_idx = '0;
      end

      job.x0         = place_x[8:0];
      job.y0         = place_y;
      job.rom_base   = ROM_AW'(glyph_idx) * ROM_AW'(GLYPH_COLS) + ROM_AW'(GLYPH_COLS - 1);
      job.fg_color   = fg_color;
      job.back_color = back_color;
      job.last_col   = (rem_x > 10'(GLYPH_COLS - 1)) ? 3'(GLYPH_COLS - 1) : rem_x[2:0];
      job.last_row   = (rem_y > 9'(GLYPH_ROWS - 1)) ? 3'(GLYPH_ROWS - 1) : rem_y[2:0];
      job_load       = accept && draw && rows_on;

      cursor_x_in   = cursor_x_ff;
      cursor_row_in = cursor_row_ff;
      if (accept) begin
         cursor_x_in   = draw ? place_x + CELL_ADVANCE : place_x;
         cursor_row_in = place_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_x_ff   <= cursor_x_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

@@ sv/tgr_raster.sv @@
// Pixel walker: glyph ROM reads, one pixel per cycle while rsp_stall is low, registered output beat
module tgr_raster import tgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_load,
   input  tgr_job_type job,
   output logic        busy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [15:0] rsp_dot_color,
   output logic        rsp_last_pixel
);

   tgr_job_type job_ff, job_in;
   logic        job_valid_ff, job_valid_in;
   logic [2:0]  col_ff, col_in;
   logic [2:0]  row_ff, row_in;
   logic        out_en;
   logic        issue;
   logic        issue_last;

   logic        out_valid_ff;
   logic [7:0]  px_ff;
   logic [7:0]  py_ff;
   logic [2:0]  bit_sel_ff;
   logic        last_ff;
   logic [15:0] fg_ff;
   logic [15:0] bg_ff;
   logic [7:0]  rom_data_ff;

   always_comb begin
      out_en     = !out_valid_ff || !rsp_stall;
      issue      = job_valid_ff && out_en;
      issue_last = (col_ff == job_ff.last_col) && (row_ff == job_ff.last_row);
      busy       = job_valid_ff && !(issue && issue_last);

      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (issue) begin
         if (issue_last) begin
            job_valid_in = 1'b0;
         end else if (row_ff == job_ff.last_row) begin
            row_in = '0;
            col_in = col_ff + 3'd1;
         end else begin
            row_in = row_ff + 3'd1;
         end
      end
      if (job_load) begin
         job_in       = job;
         job_valid_in = 1'b1;
         col_in       = '0;
         row_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (reset) begin
         job_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         if (out_en) begin
            out_valid_ff <= job_valid_ff;
         end
      end
      if (issue) begin
         px_ff       <= job_ff.x0[7:0] + {5'b0, col_ff};
         py_ff       <= job_ff.y0 + {5'b0, row_ff};
         bit_sel_ff  <= row_ff;
         last_ff     <= issue_last;
         fg_ff       <= job_ff.fg_color;
         bg_ff       <= job_ff.back_color;
         // column c of the cell reads byte 4-c of the glyph
         rom_data_ff <= GLYPH_ROM[job_ff.rom_base - ROM_AW'(col_ff)];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_x    = px_ff;
   assign rsp_pixel_y    = py_ff;
   assign rsp_dot_color  = rom_data_ff[bit_sel_ff] ? fg_ff : bg_ff;
   assign rsp_last_pixel = last_ff;

endmodule

@@ sv/text_glyph_rasterizer.sv @@
// Top level of the 5x8 bitmap-font glyph rasterizer
// Each req beat is one character; the block emits the visible pixels of its 5x8 cell, one
// rsp beat per cycle while rsp_stall is low, column by column and top row first within a
// column, with last_pixel on the final one. A character that draws nothing (cursor at or
// past the right edge, or cell below the bottom) emits no beats. The rate is set by the
// single-pixel output port and the glyph ROM, which delivers one column byte per read. The
// next character is accepted in the cycle that the previous one issues its last pixel, so
// characters stream without gaps while the result side keeps up.
module text_glyph_rasterizer import tgr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic [8:0]  req_start_x,
   input  logic [7:0]  req_start_y,
   input  logic        req_new_string,
   input  logic [15:0] req_fg_color,
   input  logic [15:0] req_back_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [15:0] rsp_dot_color,
   output logic        rsp_last_pixel
);

   logic        busy;
   logic        accept;
   logic        job_load;
   tgr_job_type job;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   tgr_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .new_string(req_new_string),
      .fg_color  (req_fg_color),
      .back_color(req_back_color),
      .job_load  (job_load),
      .job       (job)
   );

   tgr_raster u_raster (
      .clock         (clock),
      .reset         (reset),
      .job_load      (job_load),
      .job           (job),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_dot_color (rsp_dot_color),
      .rsp_last_pixel(rsp_last_pixel)
   );

endmodule

@@ sv/tgr_checker.sv @@
// Port-level checker for the glyph rasterizer, bound to the top level
`include "text_glyph_rasterizer_assert.svh"

module tgr_checker import tgr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_pixel_x,
   input logic [7:0]  rsp_pixel_y,
   input logic [15:0] rsp_dot_color,
   input logic        rsp_last_pixel
);

   `TGR_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "rsp_valid right after reset")

   `TGR_ASSERT(a_stalled_beat_holds, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_dot_color) && $stable(rsp_last_pixel), "stalled rsp beat changed")

   `TGR_ASSERT(a_x_on_screen, rsp_valid |-> (SCREEN_WIDTH > 256) || (rsp_pixel_x < SCREEN_WIDTH), "pixel_x off screen")

   `TGR_ASSERT(a_y_on_screen, rsp_valid |-> (SCREEN_HEIGHT > 256) || (rsp_pixel_y < SCREEN_HEIGHT), "pixel_y off screen")

   `TGR_ASSERT(a_cell_no_gap, rsp_valid && !rsp_stall && !rsp_last_pixel |=> rsp_valid, "gap inside a character")

endmodule

bind text_glyph_rasterizer tgr_checker #(
   .SCREEN_WIDTH (SCREEN_WIDTH),
   .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tgr_checker (.*);

@@ bench/text_glyph_rasterizer_tb.sv @@
// Self-checking bench: glyph pixel stream vs. a cursor/font predictor, with random flow control
module text_glyph_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W     = 240;
   localparam int SCREEN_H     = 135;
   localparam int CODE_FIRST   = 32;
   localparam int CODE_LAST    = 90;
   localparam int ADVANCE      = 6;
   localparam int RANDOM_CHARS = 150;
   localparam int SETTLE       = 100;
   localparam int CYCLE_LIMIT  = 200000;

   // five column bytes per glyph, first ROM byte in the top byte; column c is bits [8c+7:8c]
   localparam logic [39:0] FONT [59] = '{
      40'h00_00_00_00_00, 40'h00_00_FA_00_00, 40'h00_E0_00_E0_00, 40'h28_FE_28_FE_28,
      40'h48_54_FE_54_24, 40'h46_26_10_C8_C4, 40'h6C_92_AA_44_0A, 40'h00_C0_A0_00_00,
      40'h00_82_44_38_00, 40'h00_38_44_82_00, 40'h28_10_7C_10_28, 40'h10_10_7C_10_10,
      40'h00_00_0C_0A_00, 40'h10_10_10_10_10, 40'h00_00_06_06_00, 40'h04_08_10_20_40,
      40'h7C_8A_92_A2_7C, 40'h00_42_FE_02_00, 40'h42_86_8A_92_62, 40'h84_82_A2_D2_8C,
      40'h18_28_48_FE_08, 40'hE4_A2_A2_A2_9C, 40'h3C_52_92_92_0C, 40'h80_8E_90_A0_C0,
      40'h6C_92_92_92_6C, 40'h60_92_92_94_78, 40'h00_6C_6C_00_00, 40'h00_6A_6C_00_00,
      40'h00_82_44_28_10, 40'h28_28_28_28_28, 40'h10_28_44_82_00, 40'h60_80_8A_90_60,
      40'h4C_92_9E_82_7C, 40'h7E_88_88_88_7E, 40'hFE_92_92_92_6C, 40'h44_82_82_82_7C,
      40'h38_44_82_82_FE, 40'h82_92_92_92_FE, 40'h80_90_90_90_FE, 40'h5E_92_92_82_7C,
      40'hFE_10_10_10_FE, 40'h00_82_FE_82_00, 40'h80_FC_82_02_04, 40'h82_44_28_10_FE,
      40'h02_02_02_02_FE, 40'hFE_40_30_40_FE, 40'hFE_08_10_20_FE, 40'h7C_82_82_82_7C,
      40'h60_90_90_90_FE, 40'h7A_84_8A_82_7C, 40'h62_94_98_90_FE, 40'h8C_92_92_92_62,
      40'h80_80_FE_80_80, 40'hFC_02_02_02_FC, 40'hF8_04_02_04_F8, 40'hFC_02_1C_02_FC,
      40'hC6_28_10_28_C6, 40'hE0_10_0E_10_E0, 40'h86_8A_92_A2_C2
   };

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] color;
      logic        last;
   } glyph_pixel_type;

   typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = '0;
   logic [8:0]  req_start_x = '0;
   logic [7:0]  req_start_y = '0;
   logic        req_new_string = 1'b0;
   logic [15:0] req_fg_color = '0;
   logic [15:0] req_back_color = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pixel_x;
   logic [7:0]  rsp_pixel_y;
   logic [15:0] rsp_dot_color;
   logic        rsp_last_pixel;

   glyph_pixel_type pending_pixels [$];
   logic [9:0]      pen_x   = '0;
   logic [7:0]      pen_row = '0;
   int              errors = 0;
   int              drawn_chars = 0;
   int              cycles = 0;
   int              rsp_hold_cycles = 0;
   int              burst_left = 0;
   bit              gaps_on = 1'b1;

   text_glyph_rasterizer #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_new_string  (req_new_string),
      .req_fg_color    (req_fg_color),
      .req_back_color  (req_back_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_dot_color   (rsp_dot_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   always #10 clock = ~clock;

   // queues the visible pixels of one character and moves the cursor; returns pixel count
   function automatic int predict_char_pixels(input logic [7:0] code, input logic [8:0] sx,
         input logic [7:0] sy, input logic fresh, input logic [15:0] fg,
         input logic [15:0] bg);
      logic [5:0]      glyph;
      logic [7:0]      col_bits;
      logic [9:0]      px;
      logic [8:0]      py;
      glyph_pixel_type pix;
      glyph_pixel_type cell_px [$];
      if (fresh) begin
         pen_x   = {1'b0, sx};
         pen_row = sy;
      end
      if (pen_x >= SCREEN_W) return 0;
      glyph = (code < CODE_FIRST || code > CODE_LAST) ? 6'd0 : 6'(code - CODE_FIRST);
      for (int c = 0; c < 5; c++) begin
         col_bits = FONT[glyph][8*c +: 8];
         for (int r = 0; r < 8; r++) begin
            px = pen_x + 10'(c);
            py = {1'b0, pen_row} + 9'(r);
            if (px < SCREEN_W && py < SCREEN_H) begin
               pix.x     = px[7:0];
               pix.y     = py[7:0];
               pix.color = col_bits[r] ? fg : bg;
               pix.last  = 1'b0;
               cell_px.push_back(pix);
            end
         end
      end
      foreach (cell_px[i]) begin
         pix      = cell_px[i];
         pix.last = (i == cell_px.size() - 1);
         pending_pixels.push_back(pix);
      end
      pen_x = pen_x + 10'(ADVANCE);
      return cell_px.size();
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // input and output beats, sampled at the same edge
   always @(posedge clock) begin : beat_monitor
      glyph_pixel_type want;
      int              n;
      cycles++;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            n = predict_char_pixels(req_char_code, req_start_x, req_start_y, req_new_string,
                                    req_fg_color, req_back_color);
            if (n > 0) drawn_chars <= drawn_chars + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected pixel beat x=%0d y=%0d color=0x%0h last=%0b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_dot_color, rsp_last_pixel);
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_x", {8'd0, want.x}, {8'd0, rsp_pixel_x});
               check_field("pixel_y", {8'd0, want.y}, {8'd0, rsp_pixel_y});
               check_field("dot_color", want.color, rsp_dot_color);
               check_field("last_pixel", {15'd0, want.last}, {15'd0, rsp_last_pixel});
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d pixels outstanding", $time, pending_pixels.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // result-side backpressure: long hold on request, else random phases
   always @(posedge clock) begin : rsp_backpressure
      static rx_mode_type rx_mode = RX_FREE;
      static int          phase_left = 0;
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else begin
         if (phase_left == 0) begin
            rx_mode    = rx_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(10, 150);
         end
         phase_left--;
         case (rx_mode)
            RX_FREE:     rsp_stall <= 1'b0;
            RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_stall <= (phase_left % 3 == 0);
         endcase
      end
   end

   task automatic pace_sender();
      if (!gaps_on) return;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_char(input logic [7:0] code, input logic [8:0] sx, input logic [7:0] sy,
         input logic fresh, input logic [15:0] fg, input logic [15:0] bg);
      req_valid      <= 1'b1;
      req_char_code  <= code;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_new_string <= fresh;
      req_fg_color   <= fg;
      req_back_color <= bg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pace_sender();
   endtask

   task automatic wait_for_drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_char_code();
      if ($urandom_range(0, 99) < 85) return 8'($urandom_range(CODE_FIRST, CODE_LAST));
      return 8'($urandom_range(0, 255));
   endfunction

   // continuation right after reset, every printable extreme, out-of-range codes
   task automatic test_glyph_codes();
      send_char(8'd72, 9'd511, 8'd255, 1'b0, 16'hFFFF, 16'h0000);
      send_char(8'd65, 9'd0, 8'd0, 1'b0, 16'hFFFF, 16'h0000);
      send_char(8'd32, 9'd0, 8'd0, 1'b1, 16'h0000, 16'hFFFF);
      send_char(8'd90, 9'd0, 8'd0, 1'b0, 16'h0000, 16'hFFFF);
      send_char(8'd33, 9'd0, 8'd0, 1'b0, 16'h5555, 16'hAAAA);
      send_char(8'd48, 9'd0, 8'd0, 1'b0, 16'hAAAA, 16'h5555);
      send_char(8'd31, 9'd0, 8'd0, 1'b0, 16'hF800, 16'h07E0);
      send_char(8'd91, 9'd0, 8'd0, 1'b0, 16'h001F, 16'hF800);
      send_char(8'd0, 9'd0, 8'd0, 1'b0, 16'hFFFF, 16'h0000);
      send_char(8'd255, 9'd0, 8'd0, 1'b0, 16'h0000, 16'hFFFF);
      send_char(8'd127, 9'd0, 8'd0, 1'b0, 16'h1234, 16'hFEDC);
   endtask

   // right and bottom edges, cursor stuck past the edge, fully hidden cells
   task automatic test_clipping();
      send_char(8'd87, 9'd234, 8'd60, 1'b1, 16'hFFFF, 16'h0000);
      send_char(8'd88, 9'd0, 8'd0, 1'b0, 16'hFFFF, 16'h0000);
      send_char(8'd89, 9'd0, 8'd0, 1'b0, 16'hFFFF, 16'h0000);
      send_char(8'd35, 9'd236, 8'd10, 1'b1, 16'hABCD, 16'h4321);
      send_char(8'd77, 9'd239, 8'd20, 1'b1, 16'hABCD, 16'h4321);
      send_char(8'd77, 9'd240, 8'd20, 1'b1, 16'hABCD, 16'h4321);
      send_char(8'd77, 9'd511, 8'd0, 1'b1, 16'hABCD, 16'h4321);
      send_char(8'd66, 9'd100, 8'd130, 1'b1, 16'h0F0F, 16'hF0F0);
      send_char(8'd56, 9'd0, 8'd0, 1'b0, 16'h0F0F, 16'hF0F0);
      send_char(8'd75, 9'd50, 8'd134, 1'b1, 16'h0F0F, 16'hF0F0);
      send_char(8'd75, 9'd50, 8'd135, 1'b1, 16'h0F0F, 16'hF0F0);
      send_char(8'd75, 9'd0, 8'd0, 1'b0, 16'h0F0F, 16'hF0F0);
      send_char(8'd75, 9'd200, 8'd255, 1'b1, 16'h0F0F, 16'hF0F0);
      send_char(8'd64, 9'd238, 8'd133, 1'b1, 16'hFFFF, 16'h0000);
   endtask

   // result side held off while a gapless string keeps coming
   task automatic test_rsp_hold();
      gaps_on = 1'b0;
      rsp_hold_cycles = 400;
      send_char(rand_char_code(), 9'd6, 8'd40, 1'b1, 16'($urandom), 16'($urandom));
      repeat (11) send_char(rand_char_code(), 9'($urandom), 8'($urandom), 1'b0,
                            16'($urandom), 16'($urandom));
      gaps_on = 1'b1;
   endtask

   // sender pauses until the block is empty, then resumes mid-string
   task automatic test_drain_pause();
      wait_for_drain(SETTLE);
      repeat (3) send_char(rand_char_code(), 9'($urandom), 8'($urandom), 1'b0,
                           16'($urandom), 16'($urandom));
   endtask

   // mostly well-formed strings with random content, some noise beats
   task automatic test_random_text();
      logic [8:0]  sx;
      logic [7:0]  sy;
      logic [15:0] fg;
      logic [15:0] bg;
      int          len;
      while (drawn_chars < RANDOM_CHARS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 8) begin
            sx  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(200, 260))
                                              : 9'($urandom_range(0, 234));
            sy  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(125, 140))
                                              : 8'($urandom_range(0, 127));
            fg  = 16'($urandom);
            bg  = 16'($urandom);
            len = $urandom_range(1, 12);
            send_char(rand_char_code(), sx, sy, 1'b1, fg, bg);
            for (int k = 1; k < len; k++) begin
               if ($urandom_range(0, 4) == 0) begin
                  fg = 16'($urandom);
                  bg = 16'($urandom);
               end
               send_char(rand_char_code(), 9'($urandom), 8'($urandom), 1'b0, fg, bg);
            end
         end else begin
            send_char(8'($urandom), 9'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                      16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_glyph_codes();
      test_clipping();
      test_rsp_hold();
      test_drain_pause();
      test_random_text();
      wait_for_drain(SETTLE);
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0t ns: %0d errors, %0d pixels outstanding", $time, errors,
                  pending_pixels.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/tgr_pkg.sv
sv/tgr_front.sv
sv/tgr_raster.sv
sv/text_glyph_rasterizer.sv
sv/tgr_checker.sv
bench/text_glyph_rasterizer_tb.sv
